[src/unique_prefix_command_match_macros.svh]
// Assertion helpers for the prefix matcher. Both sample on clk and are
// disabled while rst_n is low.
`ifndef UNIQUE_PREFIX_COMMAND_MATCH_MACROS_SVH
`define UNIQUE_PREFIX_COMMAND_MATCH_MACROS_SVH

// cons must hold in the same cycle as ante
`define UPCM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define UPCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/upcm_pkg.sv]
package upcm_pkg;

  localparam int ENTRIES  = 64;
  localparam int NAME_LEN = 32;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int POS_W    = $clog2(NAME_LEN);
  localparam int LEN_W    = $clog2(NAME_LEN + 1);
  // issue register plus one register per cell
  localparam int LAT      = ENTRIES + 1;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic [1:0] ST_UNIQUE = 2'd0;
  localparam logic [1:0] ST_NONE   = 2'd1;
  localparam logic [1:0] ST_AMBIG  = 2'd2;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFS  = 8'h20;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_CLEAR,
    OP_WRITE,
    OP_QUERY
  } op_t;

  // Command part of a token; pos is the write position or the query position.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [POS_W-1:0] pos;
    logic [7:0]       ch;
    logic             last;
    logic             char_en;
    logic             drop_all;
    logic             fin;
    logic             nonempty;
  } cmd_t;

  // Match result gathered as a final query token walks the chain.
  typedef struct packed {
    logic                     found;
    logic                     ambig;
    logic [IDX_W-1:0]         best_idx;
    logic [LEN_W-1:0]         best_len;
    logic [NAME_LEN-1:0][7:0] best_name;
  } acc_t;

  typedef struct packed {
    op_t  op;
    cmd_t cmd;
    acc_t acc;
  } tok_t;

endpackage

[src/unique_prefix_command_match.sv]
// Unique prefix command matcher.
// Input: an item is taken at a rising edge with start high and busy low.
//   in_req_type 0 clears the name table, 1 writes one name character
//   (in_entry_index, in_char_pos, in_char_code; in_is_last sets the name
//   length and marks the entry valid), 2 streams one query character.
//   Query characters are upper-cased; a space ends the word and the rest
//   is ignored until in_is_last.
// Output: a query character with in_is_last high yields one result:
//   out_valid is high for exactly one cycle with out_match_status
//   (0 unique, 1 none, 2 ambiguous) and out_match_entry (the entry on a
//   unique match, else 0). The receiver cannot hold a result off.
// Timing: every item becomes a token that walks a chain of 64 cells, one
//   cell per cycle, high entry first. The result of the final query item
//   passes the issue register and then one register per cell.
//   Cells only act on tokens in arrival order, so a new item can be taken
//   every cycle; busy stays low.
// Reset: the table is empty (all entries invalid, length zero) and the query
//   state is restarted. Stored name bytes are not cleared.
`include "unique_prefix_command_match_macros.svh"

module unique_prefix_command_match (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_req_type,
  input  logic [5:0] in_entry_index,
  input  logic [4:0] in_char_pos,
  input  logic [7:0] in_char_code,
  input  logic       in_is_last,
  output logic       out_valid,
  output logic [1:0] out_match_status,
  output logic [5:0] out_match_entry
);
  import upcm_pkg::*;

  // query front end state
  logic [LEN_W-1:0] qlen_r, qlen_nxt;
  logic             word_ended_r, word_ended_nxt;
  // issue register feeding the head cell
  op_t              head_op_r, head_op_nxt;
  cmd_t             head_cmd_r, head_cmd_nxt;

  logic             accept;
  logic             fin_acc;
  logic             wr_ok;
  logic [7:0]       uc;
  logic             is_space;
  logic             char_en;
  logic             drop_all;
  logic [LEN_W-1:0] qlen_after;

  // chain_tok[ENTRIES] enters the top cell, chain_tok[0] leaves the bottom
  tok_t             chain_tok [ENTRIES+1];
  tok_t             tail;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign fin_acc = accept && (in_req_type == REQ_QUERY) && in_is_last;

  // names beyond the table or the name length are dropped
  assign wr_ok = (int'(in_entry_index) < ENTRIES) && (int'(in_char_pos) < NAME_LEN);

  always_comb begin
    uc = ((in_char_code >= CH_LOW_A) && (in_char_code <= CH_LOW_Z)) ?
         (in_char_code - CASE_OFS) : in_char_code;
    is_space = (uc == CH_SPACE);
    char_en  = !word_ended_r && !is_space;
    // a word past the longest name knocks out every entry
    drop_all = (qlen_r >= LEN_W'(NAME_LEN));
    qlen_after = (char_en && !drop_all) ? (qlen_r + LEN_W'(1)) : qlen_r;

    qlen_nxt       = qlen_r;
    word_ended_nxt = word_ended_r;
    head_op_nxt    = OP_NOP;

    head_cmd_nxt.idx      = IDX_W'(in_entry_index);
    head_cmd_nxt.pos      = POS_W'(in_char_pos);
    head_cmd_nxt.ch       = in_char_code;
    head_cmd_nxt.last     = in_is_last;
    head_cmd_nxt.char_en  = char_en;
    head_cmd_nxt.drop_all = drop_all;
    head_cmd_nxt.fin      = in_is_last;
    head_cmd_nxt.nonempty = (qlen_after != '0);

    if (accept) begin
      unique case (in_req_type)
        REQ_CLEAR: begin
          head_op_nxt    = OP_CLEAR;
          qlen_nxt       = '0;
          word_ended_nxt = 1'b0;
        end
        REQ_WRITE: begin
          if (wr_ok) begin
            head_op_nxt = OP_WRITE;
          end
        end
        REQ_QUERY: begin
          head_cmd_nxt.pos = drop_all ? '0 : POS_W'(qlen_r);
          head_cmd_nxt.ch  = uc;
          if (char_en || in_is_last) begin
            head_op_nxt = OP_QUERY;
          end
          if (in_is_last) begin
            qlen_nxt       = '0;
            word_ended_nxt = 1'b0;
          end else begin
            qlen_nxt       = qlen_after;
            word_ended_nxt = word_ended_r || is_space;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlen_r       <= '0;
      word_ended_r <= 1'b0;
      head_op_r    <= OP_NOP;
    end else begin
      qlen_r       <= qlen_nxt;
      word_ended_r <= word_ended_nxt;
      head_op_r    <= head_op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_cmd_r <= head_cmd_nxt;
  end

  // result accumulator starts empty at the head
  assign chain_tok[ENTRIES] = {head_op_r, head_cmd_r, acc_t'('0)};

  for (genvar e = 0; e < ENTRIES; e++) begin : g_chain
    upcm_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cell_idx(IDX_W'(e)),
      .tok_in  (chain_tok[e+1]),
      .tok_out (chain_tok[e])
    );
  end

  assign tail      = chain_tok[0];
  assign out_valid = (tail.op == OP_QUERY) && tail.cmd.fin;

  always_comb begin
    if (!tail.acc.found) begin
      out_match_status = ST_NONE;
    end else if (tail.acc.ambig) begin
      out_match_status = ST_AMBIG;
    end else begin
      out_match_status = ST_UNIQUE;
    end
    out_match_entry = (out_match_status == ST_UNIQUE) ? 6'(tail.acc.best_idx) : 6'd0;
  end

  // every result traces back to a query-ending item that passed the issue register and the chain
  `UPCM_ASSERT_NOW(a_result_origin, out_valid, $past(fin_acc, LAT), "result without a final query item")
  // the query state restarts after each query
  `UPCM_ASSERT_NEXT(a_query_restart, fin_acc, (qlen_r == '0) && !word_ended_r, "query state not restarted")
  // the word length saturates at the name length
  `UPCM_ASSERT_NOW(a_qlen_bound, 1'b1, qlen_r <= LEN_W'(NAME_LEN), "query length overflow")

endmodule

[src/upcm_cell.sv]
module upcm_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [upcm_pkg::IDX_W-1:0] cell_idx,
  input  upcm_pkg::tok_t             tok_in,
  output upcm_pkg::tok_t             tok_out
);
  import upcm_pkg::*;

  logic [NAME_LEN-1:0][7:0] name_r;
  logic [LEN_W-1:0]         len_r, len_nxt;
  logic                     valid_r, valid_nxt;
  logic                     cand_r, cand_nxt;
  op_t                      op_r;
  cmd_t                     cmd_r;
  acc_t                     acc_r, acc_nxt;
  logic                     hit;
  logic                     cand_mid;
  logic                     contender;
  logic                     same;

  assign hit = (tok_in.op == OP_WRITE) && (tok_in.cmd.idx == cell_idx);

  always_comb begin
    len_nxt   = len_r;
    valid_nxt = valid_r;
    cand_nxt  = cand_r;
    acc_nxt   = tok_in.acc;
    cand_mid  = cand_r;
    contender = 1'b0;

    // full name compare against the best entry so far, up to its length
    same = (len_r == tok_in.acc.best_len);
    for (int i = 0; i < NAME_LEN; i++) begin
      if ((LEN_W'(i) < tok_in.acc.best_len) && (name_r[i] != tok_in.acc.best_name[i])) begin
        same = 1'b0;
      end
    end

    unique case (tok_in.op)
      OP_CLEAR: begin
        len_nxt   = '0;
        valid_nxt = 1'b0;
        cand_nxt  = 1'b1;
      end
      OP_WRITE: begin
        if (hit && tok_in.cmd.last) begin
          len_nxt   = LEN_W'(tok_in.cmd.pos) + LEN_W'(1);
          valid_nxt = 1'b1;
        end
      end
      OP_QUERY: begin
        if (tok_in.cmd.char_en &&
            (tok_in.cmd.drop_all || (len_r <= LEN_W'(tok_in.cmd.pos)) ||
             (name_r[tok_in.cmd.pos] != tok_in.cmd.ch))) begin
          cand_mid = 1'b0;
        end
        contender = tok_in.cmd.fin && tok_in.cmd.nonempty && cand_mid &&
                    valid_r && (len_r != '0);
        if (contender) begin
          if (!tok_in.acc.found) begin
            acc_nxt.found     = 1'b1;
            acc_nxt.best_idx  = cell_idx;
            acc_nxt.best_len  = len_r;
            acc_nxt.best_name = name_r;
          end else if (!same) begin
            acc_nxt.ambig = 1'b1;
          end
        end
        // a finished query leaves every entry a candidate again
        cand_nxt = tok_in.cmd.fin ? 1'b1 : cand_mid;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      name_r[tok_in.cmd.pos] <= tok_in.cmd.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      valid_r <= 1'b0;
      cand_r  <= 1'b1;
      op_r    <= OP_NOP;
    end else begin
      len_r   <= len_nxt;
      valid_r <= valid_nxt;
      cand_r  <= cand_nxt;
      op_r    <= tok_in.op;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= tok_in.cmd;
    acc_r <= acc_nxt;
  end

  assign tok_out = {op_r, cmd_r, acc_r};

endmodule
